/* sv/bmp_header_field_extractor_core_assert.svh */
// Assertion macros shared by the header field extractor RTL.
`ifndef BMP_HEADER_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define BMP_HEADER_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BHFE_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bhfe assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BHFE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bhfe assertion failed: next-cycle check");

`endif

/* sv/bhfe_pkg.sv */
// Constants and phase codes for the BMP header field extractor.
package bhfe_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned PART_W  = 24;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned VALUE_W = 32;

  localparam logic [7:0] SIG_FIRST  = 8'h42;  // 'B'
  localparam logic [7:0] SIG_SECOND = 8'h4D;  // 'M'

  // Phase codes: field phases run from PH_FIRST_FIELD up to PH_DONE - 1.
  localparam logic [PHASE_W-1:0] PH_SIG         = 5'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST_FIELD = 5'd1;
  localparam logic [PHASE_W-1:0] PH_DONE        = 5'd15;
  localparam logic [PHASE_W-1:0] PH_ERROR       = 5'd16;

  localparam logic [ID_W-1:0] FID_PLANES = 4'd6;
  localparam logic [ID_W-1:0] FID_BPP    = 4'd7;
  localparam logic [ID_W-1:0] FID_LAST   = 4'd13;

  // Byte index of the final byte of a field.
  localparam logic [IDX_W-1:0] IDX_LAST_SHORT = 2'd1;
  localparam logic [IDX_W-1:0] IDX_LAST_WORD  = 2'd3;

endpackage

/* sv/bmp_header_field_extractor_core.sv */
// Top level: byte-serial BMP header parser with registered input and output.
//
// Input channel: one header byte per item on in_tdata; in_tuser marks the
// first byte of a new header and restarts the parse with that byte.
// Output channel: one item per completed field, carrying the field id and
// its little-endian value on out_tdata. out_tlast marks the final field
// (important colors); out_tuser flags a bad 'BM' signature, in which case
// the id and value are zero. Bytes after the final field or after an error
// produce nothing until the next start-marked byte.
// Timing: an item is registered at the input, decoded combinationally against
// the parse state, and the result lands in the output register before it is
// offered. One byte is accepted per cycle while the receiver keeps out_tready
// high; the parse state is updated once for each decoded byte.
// Reset puts the parser in the signature phase and empties both registers.
// When the receiver stalls, the output register holds its item and the
// input register holds one more byte; in_tready drops only when both are full.
`include "bmp_header_field_extractor_core_assert.svh"

module bmp_header_field_extractor_core
  import bhfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] start_flag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] field_id, [35:4] field_value, [39:36] zero
  output logic        out_tlast,  // header_done
  output logic [0:0]  out_tuser   // [0] signature_error
);

  // Input register.
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // Parse state.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;

  // Output register.
  logic               out_v_r;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_err_r, out_err_nxt;
  logic               emit;

  logic               advance;
  logic [PHASE_W-1:0] cur_phase;
  logic [IDX_W-1:0]   cur_idx;
  logic [PART_W-1:0]  cur_part;
  logic [ID_W-1:0]    cur_id;
  logic [IDX_W-1:0]   last_idx;
  logic [VALUE_W-1:0] byte_shifted;
  logic [VALUE_W-1:0] part_mask;

  // The decode stage moves whenever the output slot is free or being drained.
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  // A start-marked byte sees a freshly reset parser.
  assign cur_phase = in_start_r ? PH_SIG : phase_r;
  assign cur_idx   = in_start_r ? '0 : idx_r;
  assign cur_part  = in_start_r ? '0 : part_r;
  assign cur_id    = ID_W'(cur_phase - PH_FIRST_FIELD);
  assign last_idx  = (cur_id == FID_PLANES || cur_id == FID_BPP) ?
                     IDX_LAST_SHORT : IDX_LAST_WORD;
  assign byte_shifted = VALUE_W'(in_byte_r) << {cur_idx, 3'b000};

  always_comb begin
    case (cur_idx)
      2'd0:    part_mask = 32'h0000_0000;
      2'd1:    part_mask = 32'h0000_00FF;
      2'd2:    part_mask = 32'h0000_FFFF;
      default: part_mask = 32'h00FF_FFFF;
    endcase
  end

  always_comb begin
    phase_nxt    = cur_phase;
    idx_nxt      = cur_idx;
    part_nxt     = cur_part;
    emit         = 1'b0;
    out_id_nxt   = '0;
    out_val_nxt  = '0;
    out_done_nxt = 1'b0;
    out_err_nxt  = 1'b0;
    if (cur_phase == PH_SIG) begin
      if (cur_idx == '0) begin
        part_nxt = PART_W'(in_byte_r);
        idx_nxt  = 2'd1;
      end else begin
        phase_nxt = (cur_part[7:0] == SIG_FIRST && in_byte_r == SIG_SECOND) ?
                    PH_FIRST_FIELD : PH_ERROR;
        idx_nxt   = '0;
        part_nxt  = '0;
        if (phase_nxt == PH_ERROR) begin
          emit        = 1'b1;
          out_err_nxt = 1'b1;
        end
      end
    end else if (cur_phase < PH_DONE) begin
      if (cur_idx < last_idx) begin
        part_nxt = (cur_idx == '0) ? PART_W'(in_byte_r) :
                   (cur_part | PART_W'(byte_shifted));
        idx_nxt  = cur_idx + 2'd1;
      end else begin
        emit         = 1'b1;
        out_id_nxt   = cur_id;
        out_val_nxt  = ({8'h00, cur_part} & part_mask) | byte_shifted;
        out_done_nxt = (cur_id == FID_LAST);
        phase_nxt    = out_done_nxt ? PH_DONE : cur_phase + 5'd1;
        idx_nxt      = '0;
        part_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      idx_r   <= '0;
      part_r  <= '0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      if (in_v_r) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        part_r  <= part_nxt;
      end
      out_v_r <= in_v_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r && emit) begin
      out_id_r   <= out_id_nxt;
      out_val_r  <= out_val_nxt;
      out_done_r <= out_done_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'h0, out_val_r, out_id_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = out_err_r;

  `BHFE_ASSERT_NOW(a_err_clean, clk, rst_n, out_v_r && out_err_r,
                   out_id_r == '0 && out_val_r == '0 && !out_done_r)
  `BHFE_ASSERT_NOW(a_done_last_id, clk, rst_n, out_v_r && out_done_r,
                   out_id_r == FID_LAST && !out_err_r)
  `BHFE_ASSERT_NOW(a_short_field, clk, rst_n,
                   out_v_r && (out_id_r == FID_PLANES || out_id_r == FID_BPP),
                   out_val_r[31:16] == 16'h0000)
  `BHFE_ASSERT_NEXT(a_idle_phase, clk, rst_n, advance && in_v_r && emit,
                    idx_r == '0 && part_r == '0)

endmodule

/* bench/bmp_header_field_extractor_core_test.sv */
// Self-checking bench for the byte-serial BMP header field extractor.
`timescale 1ns / 100ps

module bmp_header_field_extractor_core_test;
  import bhfe_pkg::*;

  localparam int unsigned HDR_BYTES   = 54;
  localparam int unsigned ITEM_TARGET = 1300;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    logic               done;
    logic               err;
  } field_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  // Parser state as the bench sees it.
  logic [PHASE_W-1:0] hdr_phase;
  logic [IDX_W-1:0]   hdr_idx;
  logic [PART_W-1:0]  hdr_partial;
  field_t             pending_fields[$];

  bit          steady;
  int unsigned useful_bytes;
  int unsigned bytes_sent;
  int unsigned fields_seen;
  int unsigned headers_done;
  int unsigned sig_errors;
  int unsigned mismatches;

  bmp_header_field_extractor_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no idling, some short gaps and the odd long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic extract_field(input logic [7:0] b, input logic start);
    field_t          f;
    logic [ID_W-1:0] id;
    logic [IDX_W-1:0] last_idx;
    int unsigned     sh;
    if (start) begin
      hdr_phase   = PH_SIG;
      hdr_idx     = '0;
      hdr_partial = '0;
    end
    if (hdr_phase == PH_SIG) begin
      if (hdr_idx == 0) begin
        hdr_partial = {16'h0, b};
        hdr_idx     = 2'd1;
      end else if (hdr_partial[7:0] == SIG_FIRST && b == SIG_SECOND) begin
        hdr_phase   = PH_FIRST_FIELD;
        hdr_idx     = '0;
        hdr_partial = '0;
      end else begin
        hdr_phase   = PH_ERROR;
        hdr_idx     = '0;
        hdr_partial = '0;
        f = '{id: '0, value: '0, done: 1'b0, err: 1'b1};
        pending_fields.push_back(f);
      end
    end else if (hdr_phase < PH_DONE) begin
      id       = ID_W'(hdr_phase - PH_FIRST_FIELD);
      last_idx = (id == FID_PLANES || id == FID_BPP) ? IDX_LAST_SHORT : IDX_LAST_WORD;
      sh       = 8 * int'(hdr_idx);
      if (hdr_idx != last_idx) begin
        if (hdr_idx == 0) hdr_partial = {16'h0, b};
        else hdr_partial[sh +: 8] = b;
        hdr_idx = hdr_idx + 2'd1;
      end else begin
        f.id    = id;
        f.value = (32'(hdr_partial) & ((32'd1 << sh) - 32'd1)) | (32'(b) << sh);
        f.done  = (id == FID_LAST);
        f.err   = 1'b0;
        pending_fields.push_back(f);
        hdr_phase   = f.done ? PH_DONE : hdr_phase + 5'd1;
        hdr_idx     = '0;
        hdr_partial = '0;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Results are checked at the edge before the byte of that edge is predicted.
  always @(posedge clk) begin : monitor
    field_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        fields_seen++;
        if (pending_fields.size() == 0) begin
          note_mismatch($sformatf("unexpected item id=%0d value=%h done=%b err=%b",
                                  out_tdata[3:0], out_tdata[35:4], out_tlast, out_tuser[0]));
        end else begin
          want = pending_fields.pop_front();
          if (want.done) headers_done++;
          if (want.err) sig_errors++;
          if (out_tdata[3:0] !== want.id || out_tdata[35:4] !== want.value ||
              out_tdata[39:36] !== 4'h0 || out_tlast !== want.done ||
              out_tuser[0] !== want.err)
            note_mismatch($sformatf(
              "expected id=%0d value=%h done=%b err=%b, got id=%0d value=%h pad=%h done=%b err=%b",
              want.id, want.value, want.done, want.err, out_tdata[3:0], out_tdata[35:4],
              out_tdata[39:36], out_tlast, out_tuser[0]));
        end
      end
      if (in_tvalid && in_tready) extract_field(in_tdata, in_tuser[0]);
    end
  end

  initial begin : receiver
    int unsigned hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !steady) hold = idle_len();
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycles, pending_fields.size());
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // The sender goes idle while it waits, so no byte is offered twice.
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
  endtask

  // Sends the first cut_at bytes of a well-formed header and holds off
  // until every result is in before the byte at pause_at.
  task automatic send_header(input int unsigned cut_at, input int unsigned pause_at);
    logic [7:0]  hdr[HDR_BYTES];
    logic [31:0] w;
    int unsigned pos;
    int unsigned nbytes;
    hdr[0] = SIG_FIRST;
    hdr[1] = SIG_SECOND;
    pos = 2;
    for (int id = 0; id <= int'(FID_LAST); id++) begin
      w = pick_word();
      nbytes = (id == int'(FID_PLANES) || id == int'(FID_BPP)) ? 2 : 4;
      for (int k = 0; k < nbytes; k++) begin
        hdr[pos] = w[8*k +: 8];
        pos++;
      end
    end
    for (int unsigned i = 0; i < HDR_BYTES && i < cut_at; i++) begin
      if (i == pause_at) wait_drain();
      send_byte(hdr[i], i == 0);
      useful_bytes++;
    end
  endtask

  task automatic send_bad_signature();
    logic [7:0] a;
    logic [7:0] b;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: a = SIG_FIRST;
      1: b = SIG_SECOND;
      default: ;
    endcase
    if (a == SIG_FIRST && b == SIG_SECOND) b = ~SIG_SECOND;
    send_byte(a, 1'b1);
    send_byte(b, 1'b0);
    useful_bytes += 2;
  endtask

  // Stray bytes, mostly without a start mark, so most are ignored.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_bad_signature();
    send_byte(SIG_FIRST, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Without a start mark these are dropped after the error.
    send_byte(SIG_FIRST, 1'b0);
    send_byte(SIG_SECOND, 1'b0);
    send_byte(SIG_SECOND, 1'b1);
    send_byte(SIG_FIRST, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(SIG_SECOND, 1'b0);
    wait_drain();
  endtask

  task automatic test_restart();
    send_byte(SIG_FIRST, 1'b1);
    send_byte(SIG_SECOND, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    // A start mark in the middle of a field, then again on the signature.
    send_byte(SIG_FIRST, 1'b1);
    send_byte(SIG_FIRST, 1'b1);
    send_byte(SIG_SECOND, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_stream();
    int unsigned n;
    int unsigned k;
    n = 0;
    while (useful_bytes < ITEM_TARGET) begin
      steady = (n % 6 == 5);
      k = $urandom_range(0, 99);
      if (n % 8 == 3) send_header(HDR_BYTES, $urandom_range(2, HDR_BYTES - 1));
      else if (k < 65) send_header(HDR_BYTES, HDR_BYTES);
      else if (k < 80) send_header($urandom_range(1, HDR_BYTES - 1), HDR_BYTES);
      else if (k < 92) send_bad_signature();
      else send_noise();
      if ($urandom_range(0, 1) == 1) send_noise();
      n++;
    end
    steady = 1'b0;
  endtask

  initial begin : main
    int unsigned waited;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tuser     = 1'b0;
    steady       = 1'b0;
    useful_bytes = 0;
    bytes_sent   = 0;
    fields_seen  = 0;
    headers_done = 0;
    sig_errors   = 0;
    mismatches   = 0;
    hdr_phase    = PH_SIG;
    hdr_idx      = '0;
    hdr_partial  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bad_signature();
    test_restart();
    test_random_stream();

    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_fields.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_fields.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", pending_fields.size()));

    $display("Sent %0d bytes, %0d of them header bytes; checked %0d field results.",
             bytes_sent, useful_bytes, fields_seen);
    $display("Saw %0d complete headers and %0d signature errors, %0d mismatches.",
             headers_done, sig_errors, mismatches);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
